[sv/rbenu_pkg.sv]
// Package for the range/bearing to east/north projection core.
// Holds CORDIC constants, the arctangent table, the CORDIC step function and
// register indexes. No dependencies.
package rbenu_pkg;

    localparam int ANGLE_BITS_DEF   = 16;
    localparam int RANGE_BITS_DEF   = 20;

    localparam int CORDIC_STEPS     = 30;
    localparam int CORDIC_PER_STAGE = 2;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;

    localparam int XW = 34;
    localparam int ZW = 33;

    localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30     = 34'sd1073741824;

    localparam logic [56:0] TERM_CAP = 57'h100000000000000;
    localparam logic [47:0] VAR_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [59:0] COV_MAX = 60'sh0007FFFFFFFFFFF;
    localparam logic signed [59:0] COV_MIN = -60'sh000800000000000;

    localparam logic [1:0] REG_RANGE_SIGMA   = 2'd0;
    localparam logic [1:0] REG_BEARING_SIGMA = 2'd1;
    localparam logic [1:0] REG_HEADING_SIGMA = 2'd2;
    localparam logic [1:0] REG_GPS_SIGMA     = 2'd3;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // one rotation step; arithmetic shift is a floor shift
    function automatic cordic_t cordic_step(input cordic_t a, input logic [4:0] i);
        cordic_t r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        dx = a.y >>> i;
        dy = a.x >>> i;
        at = signed'(ZW'(atan_turn(i)));
        if (a.z >= 0)
        begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - at;
        end
        else
        begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + at;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_unit(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        if (v > ONE_Q30)
            c = ONE_Q30;
        else if (v < -ONE_Q30)
            c = -ONE_Q30;
        else
            c = v;
        return c[31:0];
    endfunction

endpackage

[sv/range_bearing_to_enu_with_covariance_core.sv]
// Throughput one transaction per cycle while the output is not stalled.
// Stages 1-15: CORDIC, two rotations each; 16: quadrant map; 17-24: products,
// rounding, Q32 scaling split into 32-bit partial products, sums and saturation.
// Stages with no valid item are filled while later ones stall (bubbles collapse).
// Reset (rst_n, async low) clears valid bits and the sigma registers to 0; derived squares are not reset.
// Uses rbenu_pkg.
module range_bearing_to_enu_with_covariance_core #(
    parameter int ANGLE_BITS = rbenu_pkg::ANGLE_BITS_DEF,
    parameter int RANGE_BITS = rbenu_pkg::RANGE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [1:0]              wr_index,
    input  logic [15:0]             wr_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [RANGE_BITS-1:0]   target_range,
    input  logic [ANGLE_BITS-1:0]   target_bearing,
    input  logic signed [31:0]      own_east,
    input  logic signed [31:0]      own_north,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [34:0]      target_east,
    output logic signed [34:0]      target_north,
    output logic [47:0]             var_east,
    output logic signed [47:0]      cov_east_north,
    output logic [47:0]             var_north,
    output logic                    saturated
);

    localparam int NC = rbenu_pkg::CORDIC_STAGES;
    localparam int NS = NC + 9;
    localparam int RB = RANGE_BITS;
    localparam int PW = RB + 31;
    localparam int S_Q  = NC + 1;
    localparam int S_M1 = NC + 2;
    localparam int S_M2 = NC + 3;
    localparam int S_M3 = NC + 4;
    localparam int S_M4 = NC + 5;
    localparam int S_M5 = NC + 6;
    localparam int S_M6 = NC + 7;
    localparam int S_M7 = NC + 8;
    localparam int S_M8 = NC + 9;

    // configuration
    logic [15:0] range_sigma_reg, bearing_sigma_reg, heading_sigma_reg, gps_sigma_reg;
    logic [31:0] bs2_reg, hs2_reg, g2_reg;
    logic [32:0] a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_sigma_reg   <= '0;
            bearing_sigma_reg <= '0;
            heading_sigma_reg <= '0;
            gps_sigma_reg     <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rbenu_pkg::REG_RANGE_SIGMA:   range_sigma_reg   <= wr_data;
                rbenu_pkg::REG_BEARING_SIGMA: bearing_sigma_reg <= wr_data;
                rbenu_pkg::REG_HEADING_SIGMA: heading_sigma_reg <= wr_data;
                rbenu_pkg::REG_GPS_SIGMA:     gps_sigma_reg     <= wr_data;
                default: ;
            endcase
        end
    end

    // derived constants settle well before any item needs them
    always_ff @(posedge clk)
    begin
        bs2_reg <= 32'(bearing_sigma_reg) * 32'(bearing_sigma_reg);
        hs2_reg <= 32'(heading_sigma_reg) * 32'(heading_sigma_reg);
        g2_reg  <= 32'(gps_sigma_reg) * 32'(gps_sigma_reg);
        a_reg   <= 33'(bs2_reg) + 33'(hs2_reg);
    end

    // flow control
    logic [NS:1] v_reg;
    logic [NS+1:1] rdy;

    always_comb
    begin
        rdy[NS+1] = !out_stall;
        for (int k = NS; k >= 1; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_stall  = !rdy[1];
    assign out_valid = v_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (rdy[1])
                v_reg[1] <= in_valid;
            for (int k = 2; k <= NS; k++)
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // CORDIC stages
    logic [31:0] turn;
    assign turn = {target_bearing, {(32-ANGLE_BITS){1'b0}}};

    rbenu_pkg::cordic_t  cd_reg  [NC];
    logic [1:0]          cq_reg  [NC];
    logic [RB-1:0]       cr_reg  [NC];
    logic signed [31:0]  ce_reg  [NC];
    logic signed [31:0]  cn_reg  [NC];

    for (genvar k = 0; k < NC; k++)
    begin : g_cordic
        rbenu_pkg::cordic_t c_in;
        rbenu_pkg::cordic_t c_mid;
        rbenu_pkg::cordic_t c_next;
        if (k == 0)
        begin : g_first
            always_comb
            begin
                c_in.x = rbenu_pkg::CORDIC_GAIN;
                c_in.y = '0;
                c_in.z = signed'({3'b000, turn[29:0]});
            end
            always_ff @(posedge clk)
            begin
                if (rdy[1])
                begin
                    cq_reg[0] <= turn[31:30];
                    cr_reg[0] <= target_range;
                    ce_reg[0] <= own_east;
                    cn_reg[0] <= own_north;
                end
            end
        end
        else
        begin : g_rest
            always_comb
                c_in = cd_reg[k-1];
            always_ff @(posedge clk)
            begin
                if (rdy[k+1])
                begin
                    cq_reg[k] <= cq_reg[k-1];
                    cr_reg[k] <= cr_reg[k-1];
                    ce_reg[k] <= ce_reg[k-1];
                    cn_reg[k] <= cn_reg[k-1];
                end
            end
        end
        always_comb
        begin
            c_mid  = rbenu_pkg::cordic_step(c_in, 5'(2*k));
            c_next = rbenu_pkg::cordic_step(c_mid, 5'(2*k+1));
        end
        always_ff @(posedge clk)
        begin
            if (rdy[k+1])
                cd_reg[k] <= c_next;
        end
    end

    // quadrant map, signs and magnitudes
    logic signed [31:0] xc, yc, s_val, c_val, ms_full, mc_full;
    logic [30:0] q_ms_reg, q_mc_reg;
    logic q_ns_reg, q_nc_reg;
    logic [RB-1:0] q_r_reg;
    logic signed [31:0] q_oe_reg, q_on_reg;

    always_comb
    begin
        xc = rbenu_pkg::clamp_unit(cd_reg[NC-1].x);
        yc = rbenu_pkg::clamp_unit(cd_reg[NC-1].y);
        case (cq_reg[NC-1])
            2'd0:    begin s_val = yc;  c_val = xc;  end
            2'd1:    begin s_val = xc;  c_val = -yc; end
            2'd2:    begin s_val = -yc; c_val = -xc; end
            default: begin s_val = -xc; c_val = yc;  end
        endcase
        ms_full = (s_val < 0) ? -s_val : s_val;
        mc_full = (c_val < 0) ? -c_val : c_val;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_Q])
        begin
            q_ms_reg <= ms_full[30:0];
            q_mc_reg <= mc_full[30:0];
            q_ns_reg <= s_val[31];
            q_nc_reg <= c_val[31];
            q_r_reg  <= cr_reg[NC-1];
            q_oe_reg <= ce_reg[NC-1];
            q_on_reg <= cn_reg[NC-1];
        end
    end

    // M1: range and sigma products
    logic [PW-1:0] m1_prs_reg, m1_prc_reg;
    logic [46:0] m1_pus_reg, m1_puc_reg;
    logic m1_ns_reg, m1_nc_reg;
    logic signed [31:0] m1_oe_reg, m1_on_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[S_M1])
        begin
            m1_prs_reg <= PW'(q_r_reg) * PW'(q_ms_reg);
            m1_prc_reg <= PW'(q_r_reg) * PW'(q_mc_reg);
            m1_pus_reg <= 47'(range_sigma_reg) * 47'(q_ms_reg);
            m1_puc_reg <= 47'(range_sigma_reg) * 47'(q_mc_reg);
            m1_ns_reg  <= q_ns_reg;
            m1_nc_reg  <= q_nc_reg;
            m1_oe_reg  <= q_oe_reg;
            m1_on_reg  <= q_on_reg;
        end
    end

    // M2: rounding
    logic [PW:0] rs_sum, rc_sum;
    logic [47:0] us_sum, uc_sum;
    logic [RB-1:0] m2_rsm_reg, m2_rcm_reg;
    logic [23:0] m2_us_reg, m2_uc_reg;
    logic m2_ns_reg, m2_nc_reg;
    logic signed [31:0] m2_oe_reg, m2_on_reg;

    always_comb
    begin
        rs_sum = (PW+1)'(m1_prs_reg) + (PW+1)'(1 << 29);
        rc_sum = (PW+1)'(m1_prc_reg) + (PW+1)'(1 << 29);
        us_sum = 48'(m1_pus_reg) + 48'(1 << 21);
        uc_sum = 48'(m1_puc_reg) + 48'(1 << 21);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_M2])
        begin
            m2_rsm_reg <= rs_sum[30 +: RB];
            m2_rcm_reg <= rc_sum[30 +: RB];
            m2_us_reg  <= us_sum[22 +: 24];
            m2_uc_reg  <= uc_sum[22 +: 24];
            m2_ns_reg  <= m1_ns_reg;
            m2_nc_reg  <= m1_nc_reg;
            m2_oe_reg  <= m1_oe_reg;
            m2_on_reg  <= m1_on_reg;
        end
    end

    // M3: squares and target point
    logic signed [34:0] rs_x, rc_x, te_next, tn_next;
    logic [63:0] m3_am_reg [3];
    logic [47:0] m3_pe_reg, m3_pn_reg, m3_px_reg;
    logic m3_ns_reg, m3_nc_reg;
    logic signed [34:0] m3_te_reg, m3_tn_reg;

    always_comb
    begin
        rs_x = signed'(35'(m2_rsm_reg));
        rc_x = signed'(35'(m2_rcm_reg));
        te_next = 35'(m2_oe_reg) + (m2_ns_reg ? -rs_x : rs_x);
        tn_next = 35'(m2_on_reg) + (m2_nc_reg ? -rc_x : rc_x);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_M3])
        begin
            m3_am_reg[0] <= 64'(m2_rcm_reg) * 64'(m2_rcm_reg);
            m3_am_reg[1] <= 64'(m2_rsm_reg) * 64'(m2_rsm_reg);
            m3_am_reg[2] <= 64'(m2_rsm_reg) * 64'(m2_rcm_reg);
            m3_pe_reg <= 48'(m2_us_reg) * 48'(m2_us_reg);
            m3_pn_reg <= 48'(m2_uc_reg) * 48'(m2_uc_reg);
            m3_px_reg <= 48'(m2_us_reg) * 48'(m2_uc_reg);
            m3_ns_reg <= m2_ns_reg;
            m3_nc_reg <= m2_nc_reg;
            m3_te_reg <= te_next;
            m3_tn_reg <= tn_next;
        end
    end

    // M4: Q32 scaling partial products, range part rounding
    logic [48:0] pe_sum, pn_sum, px_sum;
    logic [64:0] m4_lo_reg [3];
    logic [64:0] m4_hi_reg [3];
    logic [32:0] m4_pe_reg, m4_pn_reg, m4_px_reg;
    logic m4_ns_reg, m4_nc_reg;
    logic signed [34:0] m4_te_reg, m4_tn_reg;

    always_comb
    begin
        pe_sum = 49'(m3_pe_reg) + 49'(1 << 15);
        pn_sum = 49'(m3_pn_reg) + 49'(1 << 15);
        px_sum = 49'(m3_px_reg) + 49'(1 << 15);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_M4])
        begin
            for (int j = 0; j < 3; j++)
            begin
                m4_lo_reg[j] <= 65'(m3_am_reg[j][31:0]) * 65'(a_reg);
                m4_hi_reg[j] <= 65'(m3_am_reg[j][63:32]) * 65'(a_reg);
            end
            m4_pe_reg <= pe_sum[48:16];
            m4_pn_reg <= pn_sum[48:16];
            m4_px_reg <= px_sum[48:16];
            m4_ns_reg <= m3_ns_reg;
            m4_nc_reg <= m3_nc_reg;
            m4_te_reg <= m3_te_reg;
            m4_tn_reg <= m3_tn_reg;
        end
    end

    // M5: combine partials and round
    logic [97:0] sc_sum [3];
    logic [65:0] m5_q_reg [3];
    logic [32:0] m5_pe_reg, m5_pn_reg, m5_px_reg;
    logic m5_ns_reg, m5_nc_reg;
    logic signed [34:0] m5_te_reg, m5_tn_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            sc_sum[j] = {m4_hi_reg[j], 32'd0} + 98'(m4_lo_reg[j]) + 98'(64'd1 << 31);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_M5])
        begin
            for (int j = 0; j < 3; j++)
                m5_q_reg[j] <= sc_sum[j][97:32];
            m5_pe_reg <= m4_pe_reg;
            m5_pn_reg <= m4_pn_reg;
            m5_px_reg <= m4_px_reg;
            m5_ns_reg <= m4_ns_reg;
            m5_nc_reg <= m4_nc_reg;
            m5_te_reg <= m4_te_reg;
            m5_tn_reg <= m4_tn_reg;
        end
    end

    // M6: cap angular terms
    logic [56:0] m6_ang_reg [3];
    logic [32:0] m6_pe_reg, m6_pn_reg, m6_px_reg;
    logic m6_ns_reg, m6_nc_reg;
    logic signed [34:0] m6_te_reg, m6_tn_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[S_M6])
        begin
            for (int j = 0; j < 3; j++)
                m6_ang_reg[j] <= (m5_q_reg[j] > 66'(rbenu_pkg::TERM_CAP)) ?
                                 rbenu_pkg::TERM_CAP : m5_q_reg[j][56:0];
            m6_pe_reg <= m5_pe_reg;
            m6_pn_reg <= m5_pn_reg;
            m6_px_reg <= m5_px_reg;
            m6_ns_reg <= m5_ns_reg;
            m6_nc_reg <= m5_nc_reg;
            m6_te_reg <= m5_te_reg;
            m6_tn_reg <= m5_tn_reg;
        end
    end

    // M7: assemble covariance terms
    logic signed [59:0] px_s, ax_s, cov_next;
    logic [58:0] m7_ve_reg, m7_vn_reg;
    logic signed [59:0] m7_cov_reg;
    logic signed [34:0] m7_te_reg, m7_tn_reg;

    always_comb
    begin
        px_s = signed'(60'(m6_px_reg));
        ax_s = signed'(60'(m6_ang_reg[2]));
        cov_next = ((m6_ns_reg != m6_nc_reg) ? -px_s : px_s)
                 + ((m6_ns_reg == m6_nc_reg) ? -ax_s : ax_s);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_M7])
        begin
            m7_ve_reg  <= 59'(m6_pe_reg) + 59'(m6_ang_reg[0]) + 59'(g2_reg);
            m7_vn_reg  <= 59'(m6_pn_reg) + 59'(m6_ang_reg[1]) + 59'(g2_reg);
            m7_cov_reg <= cov_next;
            m7_te_reg  <= m6_te_reg;
            m7_tn_reg  <= m6_tn_reg;
        end
    end

    // M8: saturation, output register
    logic ve_clip, vn_clip, cov_hi, cov_lo;
    logic [47:0] ve_out_reg, vn_out_reg;
    logic signed [47:0] cov_out_reg;
    logic sat_out_reg;
    logic signed [34:0] te_out_reg, tn_out_reg;

    always_comb
    begin
        ve_clip = m7_ve_reg > 59'(rbenu_pkg::VAR_MAX);
        vn_clip = m7_vn_reg > 59'(rbenu_pkg::VAR_MAX);
        cov_hi  = m7_cov_reg > rbenu_pkg::COV_MAX;
        cov_lo  = m7_cov_reg < rbenu_pkg::COV_MIN;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[S_M8])
        begin
            ve_out_reg  <= ve_clip ? rbenu_pkg::VAR_MAX : m7_ve_reg[47:0];
            vn_out_reg  <= vn_clip ? rbenu_pkg::VAR_MAX : m7_vn_reg[47:0];
            cov_out_reg <= cov_hi ? rbenu_pkg::COV_MAX[47:0] :
                           (cov_lo ? rbenu_pkg::COV_MIN[47:0] : m7_cov_reg[47:0]);
            sat_out_reg <= ve_clip || vn_clip || cov_hi || cov_lo;
            te_out_reg  <= m7_te_reg;
            tn_out_reg  <= m7_tn_reg;
        end
    end

    assign target_east    = te_out_reg;
    assign target_north   = tn_out_reg;
    assign var_east       = ve_out_reg;
    assign var_north      = vn_out_reg;
    assign cov_east_north = cov_out_reg;
    assign saturated      = sat_out_reg;

endmodule

[sv/rbenu_checker.sv]
// Port-level checker for range_bearing_to_enu_with_covariance_core, bound to it below.
// Depends only on the top level's ports.
module rbenu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [34:0]  target_east,
    input logic [47:0]         var_east,
    input logic signed [47:0]  cov_east_north,
    input logic [47:0]         var_north,
    input logic                saturated
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target_east) && $stable(var_east))
        else $error("stalled result changed");

    // input side only backs up when the output is full and stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    // a saturated flag means some term sits at its limit
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (var_east == 48'hFFFF_FFFF_FFFF)
            || (var_north == 48'hFFFF_FFFF_FFFF)
            || (cov_east_north == 48'sh7FFF_FFFF_FFFF)
            || (cov_east_north == 48'sh8000_0000_0000))
        else $error("saturated without clipped term");

endmodule

bind range_bearing_to_enu_with_covariance_core rbenu_checker u_rbenu_checker (.*);

[tb/testbench.sv]
// Testbench for range_bearing_to_enu_with_covariance_core: a directed table, then random
// phases with sender gaps and receiver stalls; results are checked against known table
// rows or a built-in predictor. Depends on rbenu_pkg and the core only.
module testbench;

    typedef struct packed {
        logic signed [34:0] te;
        logic signed [34:0] tn;
        logic [47:0]        ve;
        logic signed [47:0] cov;
        logic [47:0]        vn;
        logic               sat;
    } enu_result_t;

    typedef struct {
        logic [19:0]        rng;
        logic [15:0]        brg;
        logic signed [31:0] oe;
        logic signed [31:0] on;
        bit                 has_exp;
        enu_result_t        res;
    } meas_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [1:0] wr_index = '0;
    logic [15:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [19:0] target_range = '0;
    logic [15:0] target_bearing = '0;
    logic signed [31:0] own_east = '0;
    logic signed [31:0] own_north = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [34:0] target_east;
    logic signed [34:0] target_north;
    logic [47:0] var_east;
    logic signed [47:0] cov_east_north;
    logic [47:0] var_north;
    logic saturated;

    range_bearing_to_enu_with_covariance_core u_dut (.*);

    always #1 clk = ~clk;

    longint arctan_turn [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1};

    longint unsigned sig_range, sig_bearing, sig_heading, sig_gps;
    enu_result_t pending_results[$];
    meas_row_t rows[$];
    bit cur_has_exp = 0;
    enu_result_t cur_exp;
    int gap_pct = 0;
    int stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;

    function automatic longint clamp_q30(longint v);
        if (v > 64'sd1073741824) return 64'sd1073741824;
        if (v < -64'sd1073741824) return -64'sd1073741824;
        return v;
    endfunction

    // round(m * a / 2^32), capped at 2^56
    function automatic longint unsigned angular_term(longint unsigned m, longint unsigned a);
        logic [127:0] p;
        p = ({64'b0, m} * {64'b0, a} + 128'h8000_0000) >> 32;
        if (p > 128'h100000000000000) p = 128'h100000000000000;
        return p[63:0];
    endfunction

    function automatic enu_result_t project_meas(logic [19:0] rng, logic [15:0] brg,
                                                 logic signed [31:0] oe,
                                                 logic signed [31:0] on);
        enu_result_t o;
        longint x, y, z, dx, dy, s, c, ve, vn, cov, te, tn;
        longint unsigned ms, mc, rsm, rcm, us, uc, pe, pn, px, ang, ae, an, ax, g2, r;
        logic [31:0] turn;
        bit ns, nc, sat;
        turn = {brg, 16'b0};
        x = 652032874;
        y = 0;
        z = turn[29:0];
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= arctan_turn[i];
            end
            else
            begin
                x += dx; y -= dy; z += arctan_turn[i];
            end
        end
        x = clamp_q30(x);
        y = clamp_q30(y);
        case (turn[31:30])
            2'd0: begin s = y;  c = x;  end
            2'd1: begin s = x;  c = -y; end
            2'd2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
        ns = s < 0;
        nc = c < 0;
        ms = ns ? -s : s;
        mc = nc ? -c : c;
        r = rng;
        rsm = (r * ms + (64'd1 << 29)) >> 30;
        rcm = (r * mc + (64'd1 << 29)) >> 30;
        te = longint'(oe) + (ns ? -longint'(rsm) : longint'(rsm));
        tn = longint'(on) + (nc ? -longint'(rcm) : longint'(rcm));
        us = (sig_range * ms + (64'd1 << 21)) >> 22;
        uc = (sig_range * mc + (64'd1 << 21)) >> 22;
        pe = (us * us + (64'd1 << 15)) >> 16;
        pn = (uc * uc + (64'd1 << 15)) >> 16;
        px = (us * uc + (64'd1 << 15)) >> 16;
        ang = sig_bearing * sig_bearing + sig_heading * sig_heading;
        ae = angular_term(rcm * rcm, ang);
        an = angular_term(rsm * rsm, ang);
        ax = angular_term(rsm * rcm, ang);
        g2 = sig_gps * sig_gps;
        ve = pe + ae + g2;
        vn = pn + an + g2;
        cov = (ns != nc) ? -longint'(px) : longint'(px);
        cov += (ns == nc) ? -longint'(ax) : longint'(ax);
        sat = 0;
        if (ve > 64'sd281474976710655) begin ve = 64'sd281474976710655; sat = 1; end
        if (vn > 64'sd281474976710655) begin vn = 64'sd281474976710655; sat = 1; end
        if (cov > 64'sd140737488355327) begin cov = 64'sd140737488355327; sat = 1; end
        if (cov < -64'sd140737488355328) begin cov = -64'sd140737488355328; sat = 1; end
        o.te = te[34:0];
        o.tn = tn[34:0];
        o.ve = ve[47:0];
        o.cov = cov[47:0];
        o.vn = vn[47:0];
        o.sat = sat;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // transaction monitor, checker and watchdog
    always @(posedge clk)
    begin
        enu_result_t e;
        bit moved;
        moved = 0;
        if (in_valid && !in_stall)
        begin
            moved = 1;
            pending_results.push_back(cur_has_exp ? cur_exp :
                project_meas(target_range, target_bearing, own_east, own_north));
        end
        if (out_valid && !out_stall)
        begin
            moved = 1;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                e = pending_results.pop_front();
                if (target_east !== e.te) report_mismatch("target_east", target_east, e.te);
                if (target_north !== e.tn) report_mismatch("target_north", target_north, e.tn);
                if (var_east !== e.ve) report_mismatch("var_east", var_east, e.ve);
                if (cov_east_north !== e.cov)
                    report_mismatch("cov_east_north", cov_east_north, e.cov);
                if (var_north !== e.vn) report_mismatch("var_north", var_north, e.vn);
                if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
            end
        end
        if (moved || (!in_valid && pending_results.size() == 0))
            quiet_cycles = 0;
        else if (++quiet_cycles >= 3000)
        begin
            $display("watchdog expired");
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall = ($urandom_range(99) < stall_pct);

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val;
        case (idx)
            rbenu_pkg::REG_RANGE_SIGMA:   sig_range = val;
            rbenu_pkg::REG_BEARING_SIGMA: sig_bearing = val;
            rbenu_pkg::REG_HEADING_SIGMA: sig_heading = val;
            default:                      sig_gps = val;
        endcase
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic set_sigmas(logic [15:0] rs, logic [15:0] bs, logic [15:0] hs,
                              logic [15:0] gs);
        write_reg(rbenu_pkg::REG_RANGE_SIGMA, rs);
        write_reg(rbenu_pkg::REG_BEARING_SIGMA, bs);
        write_reg(rbenu_pkg::REG_HEADING_SIGMA, hs);
        write_reg(rbenu_pkg::REG_GPS_SIGMA, gs);
    endtask

    task automatic send_meas(meas_row_t m);
        @(negedge clk);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        target_range = m.rng;
        target_bearing = m.brg;
        own_east = m.oe;
        own_north = m.on;
        cur_has_exp = m.has_exp;
        cur_exp = m.res;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        cur_has_exp = 0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic add_row(logic [19:0] rg, logic [15:0] br, logic signed [31:0] e,
                           logic signed [31:0] n, bit known, enu_result_t r);
        meas_row_t m;
        m.rng = rg; m.brg = br; m.oe = e; m.on = n; m.has_exp = known; m.res = r;
        rows.push_back(m);
    endtask

    initial
    begin
        meas_row_t m;
        enu_result_t none;
        int mode;
        none = '0;
        sig_range = 0; sig_bearing = 0; sig_heading = 0; sig_gps = 0;
        repeat (3) @(posedge clk);
        rst_n = 1'b1;

        // zero range with zero sigmas: the point is own-ship, covariance zero
        add_row(0, 16'h0000, 0, 0, 1, none);
        add_row(0, 16'h4000, 32'sh7FFFFFFF, 32'sh80000000, 1,
                '{35'sd2147483647, -35'sd2147483648, 48'd0, 48'sd0, 48'd0, 1'b0});
        add_row(0, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1,
                '{-35'sd2147483648, 35'sd2147483647, 48'd0, 48'sd0, 48'd0, 1'b0});
        add_row(20'hFFFFF, 16'h0000, 0, 0, 0, none);
        add_row(20'hFFFFF, 16'h4000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, none);
        add_row(20'hFFFFF, 16'h8000, 32'sh80000000, 32'sh80000000, 0, none);
        add_row(20'hFFFFF, 16'hC000, 32'sh7FFFFFFF, 32'sh80000000, 0, none);
        add_row(20'hFFFFF, 16'h2000, -1, 1, 0, none);
        add_row(20'hFFFFF, 16'hFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, none);
        add_row(1, 16'h0001, 0, 0, 0, none);
        add_row(20'h12345, 16'h3FFF, 123, -456, 0, none);
        add_row(20'h54321, 16'hBFFF, -789, 1011, 0, none);
        for (int k = 0; k < rows.size(); k++) send_meas(rows[k]);
        drain();

        // extreme sigmas, then a second pass over the same table
        set_sigmas(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int k = 0; k < rows.size(); k++)
        begin
            m = rows[k];
            m.has_exp = 0;
            send_meas(m);
        end
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: set_sigmas(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                1: set_sigmas(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: set_sigmas(16'($urandom_range(255)), 16'($urandom_range(255)), 16'h0000,
                              16'($urandom_range(255)));
                default: set_sigmas(16'h0000, 16'($urandom), 16'($urandom), 16'h0000);
            endcase
            mode = ph % 4;
            gap_pct = (mode == 1) ? 66 : (mode == 3) ? 18 : 0;
            stall_pct = (mode == 2) ? 66 : (mode == 3) ? 18 : 0;
            for (int k = 0; k < 200; k++)
            begin
                m.has_exp = 0;
                case ($urandom_range(9))
                    0: m.rng = 20'h00000;
                    1: m.rng = 20'hFFFFF;
                    2: m.rng = 20'($urandom_range(15));
                    default: m.rng = 20'($urandom);
                endcase
                case ($urandom_range(7))
                    0: m.brg = {2'($urandom_range(3)), 14'h0};
                    1: m.brg = {2'($urandom_range(3)), 14'h3FFF};
                    default: m.brg = 16'($urandom);
                endcase
                m.oe = ($urandom_range(9) == 0) ? 32'sh7FFFFFFF : signed'($urandom);
                m.on = ($urandom_range(9) == 0) ? 32'sh80000000 : signed'($urandom);
                // a stretch with no idling inside every phase
                if (k == 100)
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                if (k == 130)
                begin
                    gap_pct = (mode == 1) ? 66 : (mode == 3) ? 18 : 0;
                    stall_pct = (mode == 2) ? 66 : (mode == 3) ? 18 : 0;
                end
                send_meas(m);
            end
            drain();
        end
        stall_pct = 0;
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[range_bearing_to_enu_with_covariance_core.f]
sv/rbenu_pkg.sv
sv/range_bearing_to_enu_with_covariance_core.sv
sv/rbenu_checker.sv
tb/testbench.sv
